### hw/rtl/button_press_hold_double_detector_assert.svh
// Assertion macros for the button press detector.
// Every check is sampled on the rising edge of clk and is held off
// while rst_n is low.
`ifndef BUTTON_PRESS_HOLD_DOUBLE_DETECTOR_ASSERT_SVH
`define BUTTON_PRESS_HOLD_DOUBLE_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define BPHD_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bphd assertion failed");
`define BPHD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bphd assertion failed");
`define BPHD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bphd assertion failed");
`else
`define BPHD_ASSERT_ALWAYS(lbl, expr)
`define BPHD_ASSERT_IMPLY(lbl, ante, cons)
`define BPHD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/bphd_pkg.sv
package bphd_pkg;

    // Width of every tick counter and configuration register.
    localparam int TIMER_W = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBNC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = 2'd3;

    // Configuration reset values.
    localparam logic [TIMER_W-1:0] POLL_RST   = 16'd10;
    localparam logic [TIMER_W-1:0] DEBNC_RST  = 16'd20;
    localparam logic [TIMER_W-1:0] HOLD_RST   = 16'd1000;
    localparam logic [TIMER_W-1:0] DOUBLE_RST = 16'd300;

    // Gesture state codes.
    localparam logic [2:0] GS_RELEASED = 3'd0;
    localparam logic [2:0] GS_PRESSED  = 3'd1;
    localparam logic [2:0] GS_AWAIT    = 3'd2;
    localparam logic [2:0] GS_DOUBLE   = 3'd3;
    localparam logic [2:0] GS_HOLD     = 3'd4;

    // Event codes.
    localparam logic [1:0] EV_PRESSED  = 2'd0;
    localparam logic [1:0] EV_RELEASED = 2'd1;
    localparam logic [1:0] EV_HOLD     = 2'd2;
    localparam logic [1:0] EV_DOUBLE   = 2'd3;

    // Events produced by one tick, oldest in code0.
    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] code0;
        logic [1:0] code1;
    } bphd_res_t;

    // A period of zero is treated as one tick.
    function automatic logic [TIMER_W-1:0] load_ticks(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

endpackage

### hw/rtl/bphd_core.sv
module bphd_core
    import bphd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_W-1:0]   cfg_data,
    input  logic                 accept,
    input  logic                 pin_level,
    output bphd_res_t            res
);

    logic [TIMER_W-1:0] poll_reg;
    logic [TIMER_W-1:0] debnc_reg;
    logic [TIMER_W-1:0] hold_reg;
    logic [TIMER_W-1:0] double_reg;

    logic               started_reg,  started_next;
    logic               stable_reg,   stable_next;
    logic [2:0]         gstate_reg,   gstate_next;
    logic               debouncing_reg, debouncing_next;
    logic [TIMER_W-1:0] sample_reg,   sample_next;
    logic               grun_reg,     grun_next;
    logic [TIMER_W-1:0] gtimer_reg,   gtimer_next;

    // Configuration registers; writes only affect later timer loads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_reg   <= POLL_RST;
            debnc_reg  <= DEBNC_RST;
            hold_reg   <= HOLD_RST;
            double_reg <= DOUBLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLL:   poll_reg   <= cfg_data;
                CFG_DEBNC:  debnc_reg  <= cfg_data;
                CFG_HOLD:   hold_reg   <= cfg_data;
                CFG_DOUBLE: double_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // One tick: timer expiry first, then sampling, then the stable change.
    always_comb
    begin
        logic [2:0] gs;
        logic       expire;
        logic       change;
        logic       exp_ev;
        logic       chg_ev;
        logic [1:0] exp_code;
        logic [1:0] chg_code;

        started_next    = started_reg;
        stable_next     = stable_reg;
        gstate_next     = gstate_reg;
        debouncing_next = debouncing_reg;
        sample_next     = sample_reg;
        grun_next       = grun_reg;
        gtimer_next     = gtimer_reg;
        res             = '0;
        gs              = gstate_reg;
        exp_ev          = 1'b0;
        chg_ev          = 1'b0;
        exp_code        = EV_HOLD;
        chg_code        = EV_PRESSED;
        change          = 1'b0;
        expire          = 1'b0;

        if (!started_reg)
        begin
            // First tick takes the pin as the stable level.
            started_next    = 1'b1;
            stable_next     = pin_level;
            debouncing_next = 1'b0;
            sample_next     = load_ticks(poll_reg);
            res.cnt         = 2'd1;
            if (pin_level)
            begin
                gstate_next = GS_RELEASED;
                grun_next   = 1'b0;
                gtimer_next = '0;
                res.code0   = EV_RELEASED;
            end
            else
            begin
                gstate_next = GS_PRESSED;
                grun_next   = 1'b1;
                gtimer_next = load_ticks(hold_reg);
                res.code0   = EV_PRESSED;
            end
        end
        else
        begin
            gs = (gstate_reg > GS_HOLD) ? GS_RELEASED : gstate_reg;

            // Gesture timer.
            if (grun_reg)
            begin
                expire      = (gtimer_reg <= TIMER_W'(1));
                gtimer_next = expire ? '0 : gtimer_reg - TIMER_W'(1);
            end
            if (expire)
            begin
                grun_next = 1'b0;
                if (gs == GS_PRESSED)
                begin
                    gs       = GS_HOLD;
                    exp_ev   = 1'b1;
                    exp_code = EV_HOLD;
                end
                else if (gs == GS_AWAIT)
                begin
                    gs       = GS_RELEASED;
                    exp_ev   = 1'b1;
                    exp_code = EV_RELEASED;
                end
            end

            // Pin polling and debounce.
            if (sample_reg <= TIMER_W'(1))
            begin
                if (!debouncing_reg)
                begin
                    if (pin_level != stable_reg)
                    begin
                        debouncing_next = 1'b1;
                        sample_next     = load_ticks(debnc_reg);
                    end
                    else
                    begin
                        sample_next = load_ticks(poll_reg);
                    end
                end
                else
                begin
                    change          = (pin_level != stable_reg);
                    stable_next     = pin_level;
                    debouncing_next = 1'b0;
                    sample_next     = load_ticks(poll_reg);
                end
            end
            else
            begin
                sample_next = sample_reg - TIMER_W'(1);
            end

            // Gesture machine step on a stable change.
            if (change)
            begin
                case (gs)
                    GS_RELEASED:
                    begin
                        gs          = GS_PRESSED;
                        grun_next   = 1'b1;
                        gtimer_next = load_ticks(hold_reg);
                        chg_ev      = 1'b1;
                        chg_code    = EV_PRESSED;
                    end
                    GS_PRESSED:
                    begin
                        gs          = GS_AWAIT;
                        grun_next   = 1'b1;
                        gtimer_next = load_ticks(double_reg);
                    end
                    GS_AWAIT:
                    begin
                        gs          = GS_DOUBLE;
                        grun_next   = 1'b0;
                        gtimer_next = '0;
                        chg_ev      = 1'b1;
                        chg_code    = EV_DOUBLE;
                    end
                    default:
                    begin
                        gs          = GS_RELEASED;
                        grun_next   = 1'b0;
                        gtimer_next = '0;
                        chg_ev      = 1'b1;
                        chg_code    = EV_RELEASED;
                    end
                endcase
            end
            gstate_next = gs;

            // Pack events in order of occurrence.
            res.cnt = 2'({1'b0, exp_ev}) + 2'({1'b0, chg_ev});
            if (exp_ev)
            begin
                res.code0 = exp_code;
                res.code1 = chg_code;
            end
            else
            begin
                res.code0 = chg_code;
            end
        end

        if (!accept)
        begin
            res.cnt = 2'd0;
        end
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            stable_reg     <= 1'b1;
            gstate_reg     <= GS_RELEASED;
            debouncing_reg <= 1'b0;
            sample_reg     <= '0;
            grun_reg       <= 1'b0;
            gtimer_reg     <= '0;
        end
        else if (accept)
        begin
            started_reg    <= started_next;
            stable_reg     <= stable_next;
            gstate_reg     <= gstate_next;
            debouncing_reg <= debouncing_next;
            sample_reg     <= sample_next;
            grun_reg       <= grun_next;
            gtimer_reg     <= gtimer_next;
        end
    end

endmodule

### hw/rtl/bphd_fifo.sv
module bphd_fifo
    import bphd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  bphd_res_t  res,
    output logic       space,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_code,
    output logic       last
);

    // DEPTH is a power of two, at least 2, so pointers wrap on their own.
    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [1:0]    code_mem [DEPTH];
    logic          last_mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr1;
    logic          pop;

    assign wr_ptr1    = PW'(wr_ptr_reg + 1'b1);
    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && out_ready;
    assign space      = (count_reg <= CW'(DEPTH - 2));
    assign event_code = code_mem[rd_ptr_reg];
    assign last       = last_mem[rd_ptr_reg];

    // Result storage; the final event of a tick carries the last mark.
    always_ff @(posedge clk)
    begin
        if (res.cnt != 2'd0)
        begin
            code_mem[wr_ptr_reg] <= res.code0;
            last_mem[wr_ptr_reg] <= (res.cnt == 2'd1);
        end
        if (res.cnt == 2'd2)
        begin
            code_mem[wr_ptr1] <= res.code1;
            last_mem[wr_ptr1] <= 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= PW'(wr_ptr_reg + PW'(res.cnt));
            if (pop)
            begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= CW'(count_reg + CW'(res.cnt) - CW'(pop));
        end
    end

endmodule

### hw/rtl/button_press_hold_double_detector.sv
// Button press, hold and double-press detector.
// Input channel (in_valid/in_ready, pin_level): one transfer is one time tick
// carrying the sampled pin, 1 released and 0 pressed. The first tick after
// reset sets the stable level and reports pressed or released.
// Output channel (out_valid/out_ready, event_code, last): each tick yields
// zero, one or two events; last marks the final event of a tick. When a
// timer expiry and a debounced level change fall in one tick, the expiry
// event comes first.
// Configuration: cfg_we writes cfg_data into register cfg_index (poll,
// debounce, hold, double-press periods, in ticks) in the same cycle.
// Events of a tick are registered into the result queue at its transfer.
// Throughput: one tick per cycle while in_ready is high; the tick state is
// registered, and in_ready stays high while the result queue (FIFO_DEPTH
// events) has room for two more events.
// A stalled receiver fills the queue and in_ready then drops until events
// are taken. Reset restores the default periods and empties the queue.
module button_press_hold_double_detector
    import bphd_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 pin_level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           event_code,
    output logic                 last
);

`include "button_press_hold_double_detector_assert.svh"

    bphd_res_t res;
    logic      accept;

    assign accept = in_valid && in_ready;

    // Tick state and event generation.
    bphd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pin_level (pin_level),
        .res       (res)
    );

    // Result queue toward the receiver.
    bphd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .space      (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .last       (last)
    );

    // An empty queue always has room for a tick.
    `BPHD_ASSERT_IMPLY(a_empty_ready, !out_valid, in_ready)
    // A tick yields at most two events.
    `BPHD_ASSERT_ALWAYS(a_max_two, res.cnt != 2'd3)
    // With two events, the first is a timer expiry: hold or released.
    `BPHD_ASSERT_IMPLY(a_expiry_first, res.cnt == 2'd2,
        res.code0 == EV_HOLD || res.code0 == EV_RELEASED)
    // After a tick with events, out_valid is high the next cycle.
    `BPHD_ASSERT_NEXT(a_event_visible, res.cnt != 2'd0, out_valid)

endmodule

### verif/bphd_checker.sv
module bphd_checker
    import bphd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_W-1:0]   cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 pin_level,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           event_code,
    input  logic                 last,
    output int                   errors,
    output int                   outstanding,
    output int                   events_seen
);

    // One predicted event of a tick.
    typedef struct packed {
        logic [1:0] code;
        logic       last;
    } tick_event_t;

    tick_event_t event_q[$];
    tick_event_t head_ev;

    int err_cnt = 0;
    int pend_cnt = 0;
    int seen_cnt = 0;

    // Shadow copy of the period registers.
    logic [TIMER_W-1:0] poll_r;
    logic [TIMER_W-1:0] debnc_r;
    logic [TIMER_W-1:0] hold_r;
    logic [TIMER_W-1:0] dbl_r;

    // Shadow copy of the debounce and gesture state.
    logic               began;
    logic               stable_lvl;
    logic               in_debounce;
    logic [TIMER_W-1:0] sample_cnt;
    logic [2:0]         gstate;
    logic               gtimer_on;
    logic [TIMER_W-1:0] gtimer;

    assign errors      = err_cnt;
    assign outstanding = pend_cnt;
    assign events_seen = seen_cnt;

    // A programmed period of zero still lasts one tick.
    function automatic logic [TIMER_W-1:0] period_of(input logic [TIMER_W-1:0] v);
        return (v != '0) ? v : TIMER_W'(1);
    endfunction

    // Advances the shadow state by one tick and queues the events it causes.
    task automatic predict_tick(input logic pin);
        logic [1:0] codes [2];
        int         n;
        logic       change;
        logic       fire;
        n = 0;
        change = 1'b0;
        if (!began) begin
            // The first tick takes the pin as the stable level.
            began = 1'b1;
            stable_lvl = pin;
            in_debounce = 1'b0;
            sample_cnt = period_of(poll_r);
            if (pin) begin
                gstate = GS_RELEASED;
                gtimer = '0;
                gtimer_on = 1'b0;
                codes[n] = EV_RELEASED;
                n = n + 1;
            end
            else begin
                gstate = GS_PRESSED;
                gtimer = period_of(hold_r);
                gtimer_on = 1'b1;
                codes[n] = EV_PRESSED;
                n = n + 1;
            end
        end
        else begin
            if (gstate > GS_HOLD)
                gstate = GS_RELEASED;

            // Gesture timer expiry is handled before any level change.
            if (gtimer_on) begin
                fire = (gtimer <= 1);
                gtimer = fire ? '0 : gtimer - 1'b1;
                if (fire) begin
                    gtimer_on = 1'b0;
                    if (gstate == GS_PRESSED) begin
                        gstate = GS_HOLD;
                        codes[n] = EV_HOLD;
                        n = n + 1;
                    end
                    else if (gstate == GS_AWAIT) begin
                        gstate = GS_RELEASED;
                        codes[n] = EV_RELEASED;
                        n = n + 1;
                    end
                end
            end

            // Polling and debounce of the pin.
            fire = (sample_cnt <= 1);
            sample_cnt = fire ? '0 : sample_cnt - 1'b1;
            if (fire) begin
                if (!in_debounce) begin
                    if (pin != stable_lvl) begin
                        in_debounce = 1'b1;
                        sample_cnt = period_of(debnc_r);
                    end
                    else begin
                        sample_cnt = period_of(poll_r);
                    end
                end
                else begin
                    if (pin != stable_lvl) begin
                        stable_lvl = pin;
                        change = 1'b1;
                    end
                    in_debounce = 1'b0;
                    sample_cnt = period_of(poll_r);
                end
            end

            // A confirmed level change moves the gesture machine.
            if (change) begin
                case (gstate)
                    GS_RELEASED:
                    begin
                        gstate = GS_PRESSED;
                        gtimer = period_of(hold_r);
                        gtimer_on = 1'b1;
                        codes[n] = EV_PRESSED;
                        n = n + 1;
                    end
                    GS_PRESSED:
                    begin
                        gstate = GS_AWAIT;
                        gtimer = period_of(dbl_r);
                        gtimer_on = 1'b1;
                    end
                    GS_AWAIT:
                    begin
                        gstate = GS_DOUBLE;
                        gtimer = '0;
                        gtimer_on = 1'b0;
                        codes[n] = EV_DOUBLE;
                        n = n + 1;
                    end
                    default:
                    begin
                        gstate = GS_RELEASED;
                        gtimer = '0;
                        gtimer_on = 1'b0;
                        codes[n] = EV_RELEASED;
                        n = n + 1;
                    end
                endcase
            end
        end

        // The final event of the tick carries last.
        for (int i = 0; i < n; i++)
            event_q.push_back(tick_event_t'{codes[i], (i == n - 1)});
    endtask

    // Outputs are checked before the tick of the same edge is predicted, since
    // the block offers events no earlier than the cycle after the transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            poll_r = POLL_RST;
            debnc_r = DEBNC_RST;
            hold_r = HOLD_RST;
            dbl_r = DOUBLE_RST;
            began = 1'b0;
            stable_lvl = 1'b1;
            in_debounce = 1'b0;
            sample_cnt = '0;
            gstate = GS_RELEASED;
            gtimer_on = 1'b0;
            gtimer = '0;
            event_q.delete();
            pend_cnt = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                seen_cnt++;
                if (event_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected event transfer: code %0d last %0b, none expected",
                             $time, event_code, last);
                end
                else begin
                    head_ev = event_q.pop_front();
                    if (event_code !== head_ev.code || last !== head_ev.last)
                        err_cnt++;
                    if (event_code !== head_ev.code)
                        $display("%0t: event_code mismatch: expected %0d, actual %0d",
                                 $time, head_ev.code, event_code);
                    if (last !== head_ev.last)
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, head_ev.last, last);
                end
            end

            if (in_valid && in_ready)
                predict_tick(pin_level);

            if (cfg_we) begin
                case (cfg_index)
                    CFG_POLL:   poll_r = cfg_data;
                    CFG_DEBNC:  debnc_r = cfg_data;
                    CFG_HOLD:   hold_r = cfg_data;
                    CFG_DOUBLE: dbl_r = cfg_data;
                    default:    ;
                endcase
            end

            pend_cnt = event_q.size();
        end
    end

endmodule

### verif/tb_top.sv
module tb_top;
    import bphd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TICK_TARGET  = 1350;
    localparam int STALL_CYCLES = 300;
    localparam logic [TIMER_W-1:0] FULL_SCALE = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_POLL;
    logic [TIMER_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 pin_level = 1'b1;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           event_code;
    logic                 last;

    int errors;
    int outstanding;
    int events_seen;

    int   cycles = 0;
    int   ticks_sent = 0;
    int   phases_run = 0;
    logic stall_req = 1'b0;
    logic stall_done = 1'b0;
    logic no_gaps = 1'b0;
    // Settled level of the simulated button.
    logic line_level = 1'b1;

    button_press_hold_double_detector uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pin_level  (pin_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .last       (last)
    );

    bphd_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pin_level   (pin_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_code  (event_code),
        .last        (last),
        .errors      (errors),
        .outstanding (outstanding),
        .events_seen (events_seen)
    );

    always #10 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d events outstanding.",
                     cycles, outstanding);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int ticks_of(input logic [TIMER_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Random period: mostly short, sometimes zero, full scale where allowed.
    function automatic logic [TIMER_W-1:0] rand_period(input logic allow_full);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        else if (allow_full && r < 12)
            return FULL_SCALE;
        else if (r < 80)
            return TIMER_W'($urandom_range(1, 6));
        return TIMER_W'($urandom_range(7, 24));
    endfunction

    // Offers one tick and waits for its transfer.
    task automatic send_tick(input logic pin);
        int gap;
        in_valid <= 1'b1;
        pin_level <= pin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every predicted event has come, then lets a tick that
    // causes no event finish inside the block.
    task automatic settle_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four period registers on consecutive cycles.
    task automatic set_periods(input logic [TIMER_W-1:0] p, input logic [TIMER_W-1:0] d,
                               input logic [TIMER_W-1:0] h, input logic [TIMER_W-1:0] w);
        logic [TIMER_W-1:0]   vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        vals = '{p, d, h, w};
        regs = '{CFG_POLL, CFG_DEBNC, CFG_HOLD, CFG_DOUBLE};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Presses and releases with lengths scaled to the periods, with glitches.
    task automatic play_button(input int span, input int need, input int n);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                len = $urandom_range(1, 2);
                repeat (len) send_tick(!line_level);
            end
            else begin
                line_level = !line_level;
                len = (r < 75) ? $urandom_range(need, span) : $urandom_range(1, span);
                repeat (len) send_tick(line_level);
            end
            sent += len;
        end
    endtask

    // One phase: idle, new periods, then a random stretch of button activity.
    task automatic run_phase(input logic [TIMER_W-1:0] p, input logic [TIMER_W-1:0] d,
                             input logic [TIMER_W-1:0] h, input logic [TIMER_W-1:0] w,
                             input int n, input logic pressure);
        int span;
        int need;
        settle_idle();
        set_periods(p, d, h, w);
        phases_run++;
        span = ticks_of(p) + ticks_of(d) + ticks_of(h) + ticks_of(w) + 4;
        if (span > 60)
            span = 60;
        need = ticks_of(p) + ticks_of(d);
        if (need > span)
            need = span;
        no_gaps = pressure || ($urandom_range(0, 3) == 0);
        if (pressure)
            stall_req = 1'b1;
        play_button(span, need, n);
    endtask

    // Receiver: bursts of ready with random gaps, and one long hold-off.
    initial
    begin
        int len;
        @(posedge clk);
        forever begin
            if (stall_req && !stall_done) begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_done = 1'b1;
            end
            else begin
                out_ready <= 1'b1;
                len = $urandom_range(1, 40);
                repeat (len) @(posedge clk);
                len = pick_gap();
                if (len > 0) begin
                    out_ready <= 1'b0;
                    repeat (len) @(posedge clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic        first_pin;
        logic [15:0] pattern;
        int          k;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First tick at the reset periods, then a quiet stretch until the
        // first poll is due.
        first_pin = 1'($urandom_range(0, 1));
        line_level = first_pin;
        send_tick(first_pin);
        repeat (9) send_tick(first_pin);

        // Zero poll and debounce periods, short hold and window: press to hold,
        // release from hold, then two short presses that each reach hold.
        settle_idle();
        set_periods('0, '0, TIMER_W'(2), TIMER_W'(3));
        phases_run++;
        pattern = 16'b0000_1110_0110_0111;
        for (int i = 15; i >= 0; i--)
            send_tick(pattern[i]);
        line_level = 1'b1;

        // Random phases; one with a long output stall, one at full-scale
        // hold and window.
        k = 0;
        while (ticks_sent < TICK_TARGET) begin
            if (k == 2)
                run_phase(TIMER_W'(1), TIMER_W'(1), TIMER_W'(2), TIMER_W'(2), 300, 1'b1);
            else if (k == 4)
                run_phase(TIMER_W'(1), TIMER_W'(2), FULL_SCALE, FULL_SCALE, 80, 1'b0);
            else
                run_phase(rand_period(1'b0), rand_period(1'b0), rand_period(1'b1),
                          rand_period(1'b1), $urandom_range(50, 130), 1'b0);
            k++;
        end

        // Last phase at full-scale poll and debounce periods.
        run_phase(FULL_SCALE, FULL_SCALE, TIMER_W'(3), TIMER_W'(3), 40, 1'b0);

        settle_idle();
        repeat (20) @(posedge clk);

        $display("Run covered %0d ticks under %0d period settings; %0d events checked.",
                 ticks_sent, phases_run, events_seen);
        $display("Settings included zero and full-scale periods and a %0d-cycle output stall.",
                 STALL_CYCLES);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
